>>> src/periodic_slot_conflict_checker_unit_assert.svh
// Assertion macros for the periodic slot conflict checker.
`ifndef PERIODIC_SLOT_CONFLICT_CHECKER_UNIT_ASSERT_SVH
`define PERIODIC_SLOT_CONFLICT_CHECKER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PSCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pscc check failed");

// Next-cycle implication, disabled during reset.
`define PSCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pscc check failed");

// Next-cycle implication that also covers reset.
`define PSCC_ASSERT_NXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("pscc reset check failed");

`endif

>>> src/pscc_pkg.sv
// Shared constants, types and control codes of the slot conflict checker.
`default_nettype none

package pscc_pkg;

  // Horizon in slots and bitmap word geometry.
  localparam int SLOT_COUNT = 65536;
  localparam int WORD_W     = 64;
  localparam int WORD_SH    = 6;
  localparam int MAP_WORDS  = (SLOT_COUNT + WORD_W - 1) / WORD_W;
  localparam int WADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  // Slot positions grow by up to two input spans past the horizon.
  localparam int POS_W      = $clog2(SLOT_COUNT + 2 * 65536) + 1;
  localparam int CNT_W      = 7;

  typedef enum logic [2:0] {
    S_SWEEP_RST,
    S_IDLE,
    S_START,
    S_SWEEP_CLR,
    S_OCC,
    S_RD,
    S_CHK,
    S_DONE
  } pscc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic clr_start;
    logic sweep;
    logic occ_start;
    logic commit;
    logic step_word;
    logic next_occ;
    logic out_load;
  } pscc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic op_clear;
    logic flag;
    logic empty;
    logic skip;
    logic clr_last;
    logic word_last;
    logic hit;
    logic period_zero;
    logic out_busy;
  } pscc_sts_t;

endpackage

`default_nettype wire

>>> src/pscc_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module pscc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  wire logic                                        clk,
  input  wire logic                                        we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                            wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> src/pscc_ctrl.sv
// Controller state machine: sequences clear sweeps, occurrences and word walks.
`default_nettype none

module pscc_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  output pscc_pkg::pscc_cmd_t      cmd,
  input  wire pscc_pkg::pscc_sts_t sts
);
  import pscc_pkg::*;

  pscc_state_t state, state_next;

  // Hold the state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP_RST;
    end else begin
      state <= state_next;
    end
  end

  // Pick the next state and drive datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    case (state)
      S_SWEEP_RST: begin
        cmd.sweep = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        if (sts.op_clear) begin
          cmd.clr_start = 1'b1;
          state_next    = S_SWEEP_CLR;
        end else if (sts.flag || sts.empty) begin
          state_next = S_DONE;
        end else begin
          state_next = S_OCC;
        end
      end
      S_SWEEP_CLR: begin
        cmd.sweep = 1'b1;
        if (sts.clr_last) begin
          state_next = S_DONE;
        end
      end
      S_OCC: begin
        if (sts.skip) begin
          state_next = S_DONE;
        end else begin
          cmd.occ_start = 1'b1;
          state_next    = S_RD;
        end
      end
      S_RD: begin
        state_next = S_CHK;
      end
      S_CHK: begin
        cmd.commit = 1'b1;
        if (sts.hit) begin
          state_next = S_DONE;
        end else if (sts.word_last) begin
          if (sts.period_zero) begin
            state_next = S_DONE;
          end else begin
            cmd.next_occ = 1'b1;
            state_next   = S_OCC;
          end
        end else begin
          cmd.step_word = 1'b1;
          state_next    = S_RD;
        end
      end
      S_DONE: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_SWEEP_RST;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> src/pscc_dp.sv
// Datapath: request registers, occurrence and word walk, bitmap RAM, result register.
`default_nettype none

module pscc_dp (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                opcode,
  input  wire logic [15:0]         slot_start,
  input  wire logic [16:0]         slot_end,
  input  wire logic [15:0]         repeat_period,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     conflict,
  input  wire pscc_pkg::pscc_cmd_t cmd,
  output pscc_pkg::pscc_sts_t      sts
);
  import pscc_pkg::*;

  localparam logic [POS_W-1:0] SLOT_LIM = POS_W'(SLOT_COUNT);

  logic                 op_r;
  logic [POS_W-1:0]     cur_s;
  logic [POS_W-1:0]     cur_e;
  logic [15:0]          period;
  logic [POS_W-1:0]     clip;
  logic [WADDR_W-1:0]   w;
  logic [WADDR_W-1:0]   last_w;
  logic [WADDR_W-1:0]   clr_cnt;
  logic                 flag;

  logic [POS_W-1:0]     end_clip_c;
  logic [POS_W-1:0]     end_m1;
  logic [POS_W-1:0]     wbase;
  logic [WORD_SH-1:0]   lo;
  logic [CNT_W-1:0]     hi_cnt;
  logic [WORD_W-1:0]    mask;
  logic [WORD_W-1:0]    rd_data;
  logic                 hit;
  logic                 ram_we;
  logic [WADDR_W-1:0]   ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;

  // Clip the current occurrence at the horizon.
  assign end_clip_c = (cur_e > SLOT_LIM) ? SLOT_LIM : cur_e;
  assign end_m1     = end_clip_c - POS_W'(1);

  // Build the slot mask of the current word.
  assign wbase  = POS_W'({last_w, {WORD_SH{1'b0}}});
  assign lo     = (w == cur_s[WORD_SH +: WADDR_W]) ? cur_s[WORD_SH-1:0] : '0;
  assign hi_cnt = (w == last_w) ? CNT_W'(clip - wbase) : CNT_W'(WORD_W);
  assign mask   = (~({WORD_W{1'b1}} << hi_cnt)) & ({WORD_W{1'b1}} << lo);
  assign hit    = |(rd_data & mask);

  // Steer the RAM write port between the sweep and the walk.
  assign ram_we    = cmd.sweep | (cmd.commit & ~hit);
  assign ram_waddr = cmd.sweep ? clr_cnt : w;
  assign ram_wdata = cmd.sweep ? '0 : (rd_data | mask);

  pscc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (w),
    .rdata (rd_data)
  );

  // Capture the request and advance occurrences and words.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= opcode;
      cur_s  <= POS_W'(slot_start);
      cur_e  <= POS_W'(slot_end);
      period <= repeat_period;
    end
    if (cmd.occ_start) begin
      w      <= cur_s[WORD_SH +: WADDR_W];
      last_w <= end_m1[WORD_SH +: WADDR_W];
      clip   <= end_clip_c;
    end
    if (cmd.step_word) begin
      w <= w + WADDR_W'(1);
    end
    if (cmd.next_occ) begin
      cur_s <= cur_s + POS_W'(period);
      cur_e <= cur_e + POS_W'(period);
    end
  end

  // Track the sweep counter and the sticky conflict flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      flag    <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        clr_cnt <= '0;
        flag    <= 1'b0;
      end else if (cmd.sweep) begin
        clr_cnt <= clr_cnt + WADDR_W'(1);
      end
      if (cmd.commit && hit) begin
        flag <= 1'b1;
      end
    end
  end

  // Hold the result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      conflict <= flag;
    end
  end

  // Report status to the controller.
  always_comb begin
    sts             = '0;
    sts.op_clear    = op_r;
    sts.flag        = flag;
    sts.empty       = (cur_e <= cur_s);
    sts.skip        = (cur_s >= SLOT_LIM);
    sts.clr_last    = (clr_cnt == WADDR_W'(MAP_WORDS - 1));
    sts.word_last   = (w == last_w);
    sts.hit         = hit;
    sts.period_zero = (period == '0);
    sts.out_busy    = out_valid & out_stall;
  end

endmodule

`default_nettype wire

>>> src/periodic_slot_conflict_checker_unit.sv
// Top level of the periodic slot conflict checker.
// Input channel (in_valid/in_stall) carries one request: opcode, slot_start,
// slot_end, repeat_period. Output channel (out_valid/out_stall) returns one
// conflict bit per request, in request order.
// A reserve request walks its covered slots one 64-slot bitmap word at a
// time through a single RAM: each occurrence opens in S_OCC, and each word
// touched is read (S_RD), then tested and written back (S_CHK). A request
// with the flag already set or an empty interval skips the walk.
// A clear request sweeps the whole map, one word per cycle: MAP_WORDS words
// (1024 at 65536 slots).
// After reset the same sweep over all MAP_WORDS words runs with in_stall high;
// no result is produced for it.
// One request is in work at a time. A finished result sits in the output
// register while the next request is taken; if the receiver stalls, the
// following result waits in the controller until the register frees up.
`default_nettype none

module periodic_slot_conflict_checker_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        opcode,
  input  wire logic [15:0] slot_start,
  input  wire logic [16:0] slot_end,
  input  wire logic [15:0] repeat_period,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             conflict
);
  import pscc_pkg::*;

  pscc_cmd_t cmd;
  pscc_sts_t sts;

  pscc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  pscc_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .slot_start    (slot_start),
    .slot_end      (slot_end),
    .repeat_period (repeat_period),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .conflict      (conflict),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

`default_nettype wire

>>> src/pscc_checker.sv
// Port-level checker of the slot conflict checker, bound to the top level.
`default_nettype none

`include "periodic_slot_conflict_checker_unit_assert.svh"

module pscc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        opcode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        conflict
);

  logic       push;
  logic       pop;
  logic       q0;
  logic       q1;
  logic [1:0] cnt;
  logic       sticky;
  logic       head_clear;
  logic       to_head;

  assign push       = in_valid & ~in_stall;
  assign pop        = out_valid & ~out_stall;
  assign head_clear = (cnt != 2'd0) & q0;
  assign to_head    = (cnt == 2'd0) || ((cnt == 2'd1) && pop);

  // Track opcodes of requests whose results are still owed.
  always_ff @(posedge clk) begin
    if (push && to_head) begin
      q0 <= opcode;
    end else if (pop) begin
      q0 <= q1;
    end
    if (push && !to_head) begin
      q1 <= opcode;
    end
  end

  // Count owed results and remember a delivered conflict until a clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt    <= 2'd0;
      sticky <= 1'b0;
    end else begin
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
      if (pop) begin
        if (head_clear) begin
          sticky <= 1'b0;
        end else if (conflict) begin
          sticky <= 1'b1;
        end
      end
    end
  end

  `PSCC_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(conflict))
  `PSCC_ASSERT_NXT_RST(a_reset_quiet, rst, in_stall && !out_valid)
  `PSCC_ASSERT_IMP(a_clear_zero, out_valid && head_clear, !conflict)
  `PSCC_ASSERT_IMP(a_sticky, out_valid && (cnt != 2'd0) && !q0 && sticky, conflict)

endmodule

bind periodic_slot_conflict_checker_unit pscc_checker u_pscc_checker (.*);

`default_nettype wire

>>> verif/tb_periodic_slot_conflict_checker_unit.sv
// Self-checking testbench for the periodic slot conflict checker unit.
`timescale 1ns / 1ps

module tb_periodic_slot_conflict_checker_unit;

  import pscc_pkg::*;

  localparam logic OP_RESERVE = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // Slot bitmap, sticky flag and the conflict bits still due from the block
  class slot_reservation_tracker;
    bit          slot_bits [SLOT_COUNT];
    bit          flag_up;
    bit          conflict_bits_due [$];
    int unsigned failures;
    int unsigned requests;
    int unsigned clears;
    int unsigned results;
    int unsigned conflicts_reported;

    function int unsigned pending();
      return conflict_bits_due.size();
    endfunction

    // Test and set [first, stop) clipped at the horizon; stop at the first taken slot
    function bit claim_span(int unsigned first, int unsigned stop);
      int unsigned k;
      if (stop > SLOT_COUNT) stop = SLOT_COUNT;
      for (k = first; k < stop; k++) begin
        if (slot_bits[k]) return 1'b1;
        slot_bits[k] = 1'b1;
      end
      return 1'b0;
    endfunction

    // Apply one accepted request and queue the flag it leaves behind
    function void note_request(logic op, logic [15:0] s, logic [16:0] e, logic [15:0] p);
      int unsigned first;
      int unsigned stop;
      requests++;
      if (op == OP_CLEAR) begin
        clears++;
        foreach (slot_bits[i]) slot_bits[i] = 1'b0;
        flag_up = 1'b0;
      end else if (!flag_up && e > {1'b0, s}) begin
        first = s;
        stop  = e;
        while (first < SLOT_COUNT) begin
          if (claim_span(first, stop)) begin
            flag_up = 1'b1;
            break;
          end
          if (p == 16'd0) break;
          first += p;
          stop  += p;
        end
      end
      conflict_bits_due.push_back(flag_up);
    endfunction

    // Compare one returned conflict bit with the oldest one due
    function void check_conflict(logic got);
      bit want;
      results++;
      if (got === 1'b1) conflicts_reported++;
      if (conflict_bits_due.size() == 0) begin
        $error("conflict: result with no request pending, actual %0d", got);
        failures++;
      end else begin
        want = conflict_bits_due.pop_front();
        if (got !== want) begin
          $error("conflict mismatch: expected %0d, actual %0d", want, got);
          failures++;
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        opcode = OP_RESERVE;
  logic [15:0] slot_start = '0;
  logic [16:0] slot_end = '0;
  logic [15:0] repeat_period = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        conflict;

  int unsigned send_gap_pct = 0;
  int unsigned recv_stall_pct = 0;

  slot_reservation_tracker sb = new();

  periodic_slot_conflict_checker_unit u_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .slot_start    (slot_start),
    .slot_end      (slot_end),
    .repeat_period (repeat_period),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .conflict      (conflict)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < recv_stall_pct);
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_conflict(conflict);
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until taken
  task automatic send_request(input logic op, input logic [15:0] s, input logic [16:0] e,
                              input logic [15:0] p);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    opcode        <= op;
    slot_start    <= s;
    slot_end      <= e;
    repeat_period <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(op, s, e, p);
  endtask

  task automatic reserve(input logic [15:0] s, input logic [16:0] e, input logic [15:0] p);
    send_request(OP_RESERVE, s, e, p);
  endtask

  task automatic clear_map();
    send_request(OP_CLEAR, 16'($urandom), 17'($urandom_range(65536)), 16'($urandom));
  endtask

  // Hold off new requests until every result has come back
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // Pick a reserve request: mostly short well-formed tasks, some noise and empty ones
  task automatic pick_reserve(output logic [15:0] s, output logic [16:0] e,
                              output logic [15:0] p);
    int unsigned kind;
    int unsigned len;
    int unsigned first;
    int unsigned stop;
    kind = $urandom_range(99);
    if (kind < 10) begin
      s = 16'($urandom);
      e = 17'($urandom_range(65536));
      p = 16'($urandom);
    end else if (kind < 16) begin
      s = 16'($urandom);
      e = 17'($urandom_range(0, s));
      p = 16'($urandom);
    end else begin
      len   = ($urandom_range(9) == 0) ? $urandom_range(65, 2048) : $urandom_range(1, 64);
      // crowd some tasks into a narrow window so conflicts happen
      first = ($urandom_range(9) < 3) ? $urandom_range(1023) : $urandom_range(65535);
      stop  = first + len;
      if (stop > SLOT_COUNT) stop = SLOT_COUNT;
      s    = 16'(first);
      e    = 17'(stop);
      kind = $urandom_range(99);
      if (kind < 40) p = '0;
      else if (kind < 85) p = 16'($urandom_range(4096, 65535));
      else if (kind < 95 || len < 2) p = 16'($urandom_range((len > 256) ? len : 256, 4095));
      else p = 16'($urandom_range(1, len - 1));
    end
  endtask

  // Run one phase: episodes of a clear followed by a burst of reserves
  task automatic run_phase(input int unsigned gap_pct, input int unsigned stall_pct,
                           input int unsigned quota);
    int unsigned sent;
    int unsigned burst;
    logic [15:0] s;
    logic [16:0] e;
    logic [15:0] p;
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < quota) begin
      clear_map();
      burst = $urandom_range(2, 24);
      repeat (burst) begin
        pick_reserve(s, e, p);
        reserve(s, e, p);
      end
      sent += burst + 1;
      if ($urandom_range(19) == 0) wait_for_drain();
    end
    wait_for_drain();
  endtask

  // Directed cases: empty intervals, horizon edges, clipping, self-overlap, held flag
  task automatic run_directed();
    reserve(16'd0, 17'd0, 16'd0);
    reserve(16'd5, 17'd5, 16'd0);
    reserve(16'd100, 17'd50, 16'd7);
    reserve(16'd0, 17'd1, 16'd0);
    reserve(16'hFFFF, 17'h10000, 16'd0);
    reserve(16'd65000, 17'd65100, 16'd500);
    reserve(16'd2000, 17'd2064, 16'hFFFF);
    reserve(16'd0, 17'd1, 16'd0);
    reserve(16'd3000, 17'd3010, 16'd0);
    clear_map();
    reserve(16'd0, 17'h10000, 16'd0);
    reserve(16'hFFFF, 17'h10000, 16'hFFFF);
    clear_map();
    reserve(16'd10, 17'd20, 16'd5);
    clear_map();
    reserve(16'd60000, 17'd60001, 16'd1);
    reserve(16'd59999, 17'd60000, 16'd0);
    reserve(16'd61000, 17'd61002, 16'd0);
    clear_map();
    reserve(16'd0, 17'h10000, 16'hFFFF);
    clear_map();
    reserve(16'hFFFF, 17'h10000, 16'd1);
    reserve(16'hAAAA, 17'hAAAB, 16'h5555);
    reserve(16'h5555, 17'h5556, 16'hAAAA);
    clear_map();
    wait_for_drain();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_phase(0, 0, 400);
    run_phase(77, 0, 400);
    run_phase(0, 77, 400);
    run_phase(20, 20, 400);
    wait_for_drain();
    repeat (64) @(posedge clk);
    $display("Covered %0d requests (%0d clears) and %0d results, %0d of them flagged,",
             sb.requests, sb.clears, sb.results, sb.conflicts_reported);
    $display("under no idling, sender gaps, receiver stalls and both together.");
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
